FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker of the keyboard matrix block.
// Depends on nothing; each macro takes a label, a clock, a reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every edge outside reset.
`define KMIC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kmic assertion failed");

// Same-cycle implication.
`define KMIC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmic implication failed");

// Next-cycle implication.
`define KMIC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmic next-cycle implication failed");

`endif

FILE: hw/rtl/kmic_pkg.sv
// Package of the keyboard matrix and interrupt block: opcode, IRQ action and port constants.
// Depends on nothing; used by the core, the checker and the testbench.
`timescale 1ns / 1ps

package kmic_pkg;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_PORT_READ   = 2'd0,
      OP_PORT_WRITE  = 2'd1,
      OP_LOAD_COLUMN = 2'd2,
      OP_LINE_CHANGE = 2'd3
   } opcode_type;

   // IRQ actions reported with each response.
   typedef enum logic [1:0] {
      IRQ_NONE   = 2'd0,
      IRQ_ASSERT = 2'd1,
      IRQ_CLEAR  = 2'd2
   } irq_action_type;

   // I/O port addresses (low byte).
   localparam logic [7:0] PortHighNibble = 8'h10;
   localparam logic [7:0] PortLowNibble  = 8'h20;
   localparam logic [7:0] PortModifier   = 8'h40;

   // Upper bits forced high on low-nibble and modifier reads.
   localparam logic [7:0] NibbleFill = 8'hF0;

   // Column roles.
   localparam logic [7:0] ReadableColumns = 8'd10;
   localparam int         ModColumn       = 10;
   localparam logic [7:0] ScanColumn      = 8'h0F;
   localparam int         ScanOrColumns   = 9;

endpackage

FILE: hw/rtl/kmic_channels.sv
// Valid/ready channel interfaces for requests and responses of the keyboard matrix block.
// Depends on nothing beyond plain logic types.
`timescale 1ns / 1ps

interface kmic_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] port;
   logic [7:0] data;
   logic [3:0] column_index;
   logic       line_level;

   modport source (output valid, opcode, port, data, column_index, line_level, input ready);
   modport sink   (input valid, opcode, port, data, column_index, line_level, output ready);
endinterface

interface kmic_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [1:0] irq_action;
   logic       nmi_pulse;
   logic       sound_write;
   logic [7:0] sound_data;

   modport source (output valid, read_data, irq_action, nmi_pulse, sound_write, sound_data,
                   input ready);
   modport sink   (input valid, read_data, irq_action, nmi_pulse, sound_write, sound_data,
                   output ready);
endinterface

FILE: hw/rtl/keyboard_matrix_interrupt_ctrl_core.sv
// Keyboard matrix and interrupt glue: one response per request, in the next cycle.
// One request per cycle unless a response stalls; the response register is the only
// pipeline stage, and a new request is taken whenever that register is empty or draining.
// Synchronous active-high reset clears the key matrix, the selected column, the last line
// level, the last key OR and the response valid flag.
// Depends on kmic_pkg and the interfaces in kmic_channels.sv.
`timescale 1ns / 1ps

module keyboard_matrix_interrupt_ctrl_core #(
   parameter int MATRIX_COLUMNS = 11
) (
   input  logic              clock,
   input  logic              reset,
   kmic_req_if.sink          req_ch,
   kmic_rsp_if.source        rsp_ch
);

   localparam int ColIdxW = $clog2(MATRIX_COLUMNS);

   // Architectural state.
   logic [7:0] key_matrix_ff [MATRIX_COLUMNS];
   logic [7:0] selected_column_ff;
   logic       last_line_level_ff;
   logic [7:0] last_key_or_ff;

   // Response register.
   logic       rsp_valid_ff;
   logic [7:0] read_data_ff,   read_data_in;
   logic [1:0] irq_action_ff,  irq_action_in;
   logic       nmi_pulse_ff,   nmi_pulse_in;
   logic       sound_write_ff, sound_write_in;
   logic [7:0] sound_data_ff,  sound_data_in;

   logic [7:0] selected_column_in;
   logic       last_line_level_in;
   logic [7:0] last_key_or_in;
   logic       load_column;

   logic       accept;
   logic       sel_readable;
   logic [7:0] sel_keys;
   logic [7:0] key_or;
   kmic_pkg::opcode_type opcode;

   // A request is taken when the response register is free or drains this cycle.
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;
   assign opcode       = kmic_pkg::opcode_type'(req_ch.opcode);

   // Column selected for key reads; only columns below ten are readable.
   assign sel_readable = selected_column_ff < kmic_pkg::ReadableColumns;
   assign sel_keys     = key_matrix_ff[selected_column_ff[ColIdxW-1:0]];

   // OR of the scanned columns, used for key-change IRQ detection.
   always_comb begin
      key_or = '0;
      for (int i = 0; i < kmic_pkg::ScanOrColumns; i++) begin
         key_or = key_or | key_matrix_ff[i];
      end
   end

   // Response fields and state updates for the current request.
   always_comb begin
      read_data_in       = '0;
      irq_action_in      = kmic_pkg::IRQ_NONE;
      nmi_pulse_in       = 1'b0;
      sound_write_in     = 1'b0;
      sound_data_in      = '0;
      selected_column_in = selected_column_ff;
      last_line_level_in = last_line_level_ff;
      last_key_or_in     = last_key_or_ff;
      load_column        = 1'b0;

      unique case (opcode)
         kmic_pkg::OP_PORT_READ: begin
            unique case (req_ch.port)
               kmic_pkg::PortHighNibble: begin
                  read_data_in = sel_readable ? {4'h0, sel_keys[7:4]} : 8'h00;
               end
               kmic_pkg::PortLowNibble: begin
                  read_data_in = sel_readable ? (kmic_pkg::NibbleFill | {4'h0, sel_keys[3:0]})
                                              : kmic_pkg::NibbleFill;
               end
               kmic_pkg::PortModifier: begin
                  read_data_in = kmic_pkg::NibbleFill
                               | {4'h0, key_matrix_ff[kmic_pkg::ModColumn][3:0]};
               end
               default: begin
                  read_data_in = '0;
               end
            endcase
         end
         kmic_pkg::OP_PORT_WRITE: begin
            unique case (req_ch.port)
               kmic_pkg::PortLowNibble: begin
                  selected_column_in = req_ch.data;
                  irq_action_in      = kmic_pkg::IRQ_CLEAR;
               end
               kmic_pkg::PortModifier: begin
                  sound_write_in = 1'b1;
                  sound_data_in  = req_ch.data;
               end
               default: begin
                  sound_write_in = 1'b0;
               end
            endcase
         end
         kmic_pkg::OP_LOAD_COLUMN: begin
            load_column = {1'b0, req_ch.column_index} < 5'(MATRIX_COLUMNS);
         end
         kmic_pkg::OP_LINE_CHANGE: begin
            nmi_pulse_in       = req_ch.line_level & ~last_line_level_ff;
            last_line_level_in = req_ch.line_level;
            if (selected_column_ff == kmic_pkg::ScanColumn) begin
               if ((key_or != 8'h00) && (key_or != last_key_or_ff)) begin
                  irq_action_in = kmic_pkg::IRQ_ASSERT;
               end
               last_key_or_in = key_or;
            end
         end
         default: begin
            load_column = 1'b0;
         end
      endcase
   end

   // State registers, updated only on accepted requests.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MATRIX_COLUMNS; i++) begin
            key_matrix_ff[i] <= '0;
         end
         selected_column_ff <= '0;
         last_line_level_ff <= 1'b0;
         last_key_or_ff     <= '0;
      end else if (accept) begin
         if (load_column) begin
            key_matrix_ff[req_ch.column_index[ColIdxW-1:0]] <= req_ch.data;
         end
         selected_column_ff <= selected_column_in;
         last_line_level_ff <= last_line_level_in;
         last_key_or_ff     <= last_key_or_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload, loaded with each accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff   <= read_data_in;
         irq_action_ff  <= irq_action_in;
         nmi_pulse_ff   <= nmi_pulse_in;
         sound_write_ff <= sound_write_in;
         sound_data_ff  <= sound_data_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_data   = read_data_ff;
   assign rsp_ch.irq_action  = irq_action_ff;
   assign rsp_ch.nmi_pulse   = nmi_pulse_ff;
   assign rsp_ch.sound_write = sound_write_ff;
   assign rsp_ch.sound_data  = sound_data_ff;

endmodule

FILE: hw/rtl/kmic_checker.sv
// Port-level checker for the keyboard matrix core, with the bind that attaches it.
// Depends on assert_macros.svh and kmic_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kmic_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic [1:0] rsp_irq_action,
   input logic       rsp_nmi_pulse,
   input logic       rsp_sound_write,
   input logic [7:0] rsp_sound_data
);

   logic        rsp_stall;
   logic [19:0] rsp_bits;
   logic        sound_only;

   // Shorthand terms used by the properties below.
   assign rsp_stall  = rsp_valid & ~rsp_ready;
   assign rsp_bits   = {rsp_read_data, rsp_irq_action, rsp_nmi_pulse, rsp_sound_write,
                        rsp_sound_data};
   assign sound_only = (rsp_read_data == 8'h00) && !rsp_nmi_pulse
                       && (rsp_irq_action == kmic_pkg::IRQ_NONE);

   // A stalled response keeps its payload.
   `KMIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_bits))

   // Every accepted request yields a response in the next cycle.
   `KMIC_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // A sound write comes only from a port write, so nothing else is reported with it.
   `KMIC_ASSERT_SAME(a_sound_alone, clock, reset, rsp_valid && rsp_sound_write, sound_only)

   // Without a sound write the forwarded byte stays zero.
   `KMIC_ASSERT_SAME(a_sound_data_idle, clock, reset, rsp_valid && !rsp_sound_write, rsp_sound_data == 8'h00)

   // The IRQ action never carries the unused code.
   `KMIC_ASSERT(a_irq_code, clock, reset, !rsp_valid || rsp_irq_action != 2'd3)

endmodule

bind keyboard_matrix_interrupt_ctrl_core kmic_checker u_kmic_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_read_data   (rsp_ch.read_data),
   .rsp_irq_action  (rsp_ch.irq_action),
   .rsp_nmi_pulse   (rsp_ch.nmi_pulse),
   .rsp_sound_write (rsp_ch.sound_write),
   .rsp_sound_data  (rsp_ch.sound_data)
);

FILE: tb/tb_keyboard_matrix_interrupt_ctrl_core.sv
// Self-checking testbench for the keyboard matrix and interrupt core: directed and random requests
// with an in-bench predictor. Depends on kmic_pkg, the channel interfaces in kmic_channels.sv
// and keyboard_matrix_interrupt_ctrl_core.
`timescale 1ns / 1ps

module tb_keyboard_matrix_interrupt_ctrl_core;

   localparam int          MatrixColumns = 11;
   localparam int unsigned StallLimit    = 1000;

   typedef struct packed {
      kmic_pkg::opcode_type op;
      logic [7:0]           port;
      logic [7:0]           data;
      logic [3:0]           col;
      logic                 level;
   } kmic_request_type;

   typedef struct packed {
      logic [7:0]               read_data;
      kmic_pkg::irq_action_type irq;
      logic                     nmi;
      logic                     snd_w;
      logic [7:0]               snd_d;
   } kmic_result_type;

   logic clock = 1'b0;
   logic reset;

   kmic_req_if req_ch ();
   kmic_rsp_if rsp_ch ();

   keyboard_matrix_interrupt_ctrl_core #(
      .MATRIX_COLUMNS(MatrixColumns)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Predicted state of the glue logic.
   logic [7:0] key_cols [MatrixColumns];
   logic [7:0] sel_col;
   logic       last_level;
   logic [7:0] last_or;

   kmic_result_type pending_responses[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count    = 0;
   int unsigned requests_taken = 0;
   int unsigned responses_seen = 0;
   int unsigned irq_asserts    = 0;
   int unsigned nmi_pulses     = 0;
   int unsigned sound_writes   = 0;
   int unsigned quiet_cycles   = 0;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the response to one request and advances the predicted state.
   function automatic kmic_result_type predict_glue_response(input kmic_request_type rq);
      kmic_result_type res;
      logic [7:0]      key_or;
      res = '0;
      res.irq = kmic_pkg::IRQ_NONE;
      case (rq.op)
         kmic_pkg::OP_PORT_READ: begin
            if (rq.port == kmic_pkg::PortHighNibble) begin
               if (sel_col < kmic_pkg::ReadableColumns)
                  res.read_data = {4'h0, key_cols[sel_col[3:0]][7:4]};
            end else if (rq.port == kmic_pkg::PortLowNibble) begin
               res.read_data = kmic_pkg::NibbleFill;
               if (sel_col < kmic_pkg::ReadableColumns)
                  res.read_data[3:0] = key_cols[sel_col[3:0]][3:0];
            end else if (rq.port == kmic_pkg::PortModifier) begin
               res.read_data = kmic_pkg::NibbleFill
                             | {4'h0, key_cols[kmic_pkg::ModColumn][3:0]};
            end
         end
         kmic_pkg::OP_PORT_WRITE: begin
            if (rq.port == kmic_pkg::PortLowNibble) begin
               sel_col = rq.data;
               res.irq = kmic_pkg::IRQ_CLEAR;
            end else if (rq.port == kmic_pkg::PortModifier) begin
               res.snd_w = 1'b1;
               res.snd_d = rq.data;
            end
         end
         kmic_pkg::OP_LOAD_COLUMN: begin
            if (rq.col < MatrixColumns) key_cols[rq.col] = rq.data;
         end
         default: begin
            res.nmi    = rq.level && !last_level;
            last_level = rq.level;
            // The key scan only runs while the scan column is selected.
            if (sel_col == kmic_pkg::ScanColumn) begin
               key_or = 8'h00;
               for (int i = 0; i < kmic_pkg::ScanOrColumns; i++) key_or |= key_cols[i];
               if (key_or != 8'h00 && key_or != last_or) res.irq = kmic_pkg::IRQ_ASSERT;
               last_or = key_or;
            end
         end
      endcase
      return res;
   endfunction

   // Prints one mismatch and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s at response %0d: got 0x%0h, expected 0x%0h",
               what, responses_seen, got, want);
      error_count++;
   endtask

   // Receiver: ready drops at random according to the current stall rate.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Checks each response against the oldest prediction, then predicts the new request.
   always @(posedge clock) begin
      kmic_result_type  want;
      kmic_request_type rq;
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
               report_mismatch("response with none outstanding", rsp_ch.read_data, 0);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_ch.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_ch.read_data, want.read_data);
               if (rsp_ch.irq_action !== want.irq)
                  report_mismatch("irq_action", rsp_ch.irq_action, want.irq);
               if (rsp_ch.nmi_pulse !== want.nmi)
                  report_mismatch("nmi_pulse", rsp_ch.nmi_pulse, want.nmi);
               if (rsp_ch.sound_write !== want.snd_w)
                  report_mismatch("sound_write", rsp_ch.sound_write, want.snd_w);
               if (rsp_ch.sound_data !== want.snd_d)
                  report_mismatch("sound_data", rsp_ch.sound_data, want.snd_d);
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            rq.op    = kmic_pkg::opcode_type'(req_ch.opcode);
            rq.port  = req_ch.port;
            rq.data  = req_ch.data;
            rq.col   = req_ch.column_index;
            rq.level = req_ch.line_level;
            want     = predict_glue_response(rq);
            if (want.irq == kmic_pkg::IRQ_ASSERT) irq_asserts++;
            if (want.nmi) nmi_pulses++;
            if (want.snd_w) sound_writes++;
            pending_responses = {pending_responses, want};
            requests_taken++;
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("no handshake for %0d cycles", StallLimit);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one request, idling first at the current rate, and waits for its acceptance.
   task automatic send_request(input kmic_pkg::opcode_type op, input logic [7:0] port,
                               input logic [7:0] data, input logic [3:0] col,
                               input logic level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.port         <= port;
      req_ch.data         <= data;
      req_ch.column_index <= col;
      req_ch.line_level   <= level;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Holds the sender back until every outstanding response has come.
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Reads of every port straight after reset, and an unmapped port.
   task automatic test_reset_reads();
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortHighNibble, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortLowNibble, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortModifier, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, 8'hFF, 8'hFF, 4'hF, 1'b1);
   endtask

   // Column loads, including indexes beyond the matrix, which must be ignored.
   task automatic test_column_loads();
      send_request(kmic_pkg::OP_LOAD_COLUMN, 8'h00, 8'hA5, 4'd0, 1'b0);
      send_request(kmic_pkg::OP_LOAD_COLUMN, 8'h00, 8'h3C, 4'd10, 1'b0);
      send_request(kmic_pkg::OP_LOAD_COLUMN, 8'h00, 8'hFF, 4'd15, 1'b0);
      send_request(kmic_pkg::OP_LOAD_COLUMN, 8'h00, 8'h55, 4'd11, 1'b0);
   endtask

   // Reads through a normal selection, the modifier column and selections of ten or more.
   task automatic test_selection_reads();
      send_request(kmic_pkg::OP_PORT_WRITE, kmic_pkg::PortLowNibble, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortHighNibble, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortLowNibble, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortModifier, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_WRITE, kmic_pkg::PortLowNibble, 8'd10, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortHighNibble, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_WRITE, kmic_pkg::PortLowNibble, 8'hFF, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_READ, kmic_pkg::PortLowNibble, 8'h00, 4'h0, 1'b0);
   endtask

   // Sound writes at both data extremes, and a write to an unmapped port.
   task automatic test_port_writes();
      send_request(kmic_pkg::OP_PORT_WRITE, kmic_pkg::PortModifier, 8'hFF, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_WRITE, kmic_pkg::PortModifier, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_PORT_WRITE, 8'h00, 8'h12, 4'h0, 1'b0);
   endtask

   // Line edges with the scan column selected: new keys, unchanged keys and an empty matrix.
   task automatic test_line_changes();
      send_request(kmic_pkg::OP_PORT_WRITE, kmic_pkg::PortLowNibble, kmic_pkg::ScanColumn,
                   4'h0, 1'b0);
      send_request(kmic_pkg::OP_LINE_CHANGE, 8'h00, 8'h00, 4'h0, 1'b1);
      send_request(kmic_pkg::OP_LINE_CHANGE, 8'h00, 8'h00, 4'h0, 1'b1);
      send_request(kmic_pkg::OP_LINE_CHANGE, 8'h00, 8'h00, 4'h0, 1'b0);
      send_request(kmic_pkg::OP_LOAD_COLUMN, 8'h00, 8'h00, 4'd0, 1'b0);
      send_request(kmic_pkg::OP_LINE_CHANGE, 8'h00, 8'h00, 4'h0, 1'b1);
      send_request(kmic_pkg::OP_LOAD_COLUMN, 8'h00, 8'h80, 4'd8, 1'b0);
      send_request(kmic_pkg::OP_LINE_CHANGE, 8'h00, 8'h00, 4'h0, 1'b0);
   endtask

   // Random traffic in four idling phases, biased towards mapped ports and valid columns.
   task automatic test_random_traffic(input int unsigned total);
      kmic_request_type rq;
      for (int unsigned phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         for (int unsigned n = 0; n < total / 4; n++) begin
            rq.op    = kmic_pkg::opcode_type'($urandom_range(3));
            rq.port  = 8'($urandom_range(255));
            rq.data  = 8'($urandom_range(255));
            rq.col   = 4'($urandom_range(15));
            rq.level = 1'($urandom_range(1));
            if (rq.op == kmic_pkg::OP_PORT_READ || rq.op == kmic_pkg::OP_PORT_WRITE) begin
               if ($urandom_range(99) < 85) begin
                  case ($urandom_range(2))
                     0: rq.port = kmic_pkg::PortHighNibble;
                     1: rq.port = kmic_pkg::PortLowNibble;
                     default: rq.port = kmic_pkg::PortModifier;
                  endcase
               end
               // Selections mostly hit the scan column or a readable one.
               if (rq.op == kmic_pkg::OP_PORT_WRITE && rq.port == kmic_pkg::PortLowNibble &&
                   $urandom_range(99) < 75)
                  rq.data = $urandom_range(1) ? kmic_pkg::ScanColumn : 8'($urandom_range(10));
            end else if (rq.op == kmic_pkg::OP_LOAD_COLUMN) begin
               if ($urandom_range(99) < 85) rq.col = 4'($urandom_range(10));
               if ($urandom_range(3) == 0) rq.data = 8'h00;
            end
            send_request(rq.op, rq.port, rq.data, rq.col, rq.level);
         end
         hold_until_drained();
      end
   endtask

   // Reset, then each test in turn, then the final verdict.
   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = kmic_pkg::OP_PORT_READ;
      req_ch.port         = 8'h00;
      req_ch.data         = 8'h00;
      req_ch.column_index = 4'h0;
      req_ch.line_level   = 1'b0;
      rsp_ch.ready        = 1'b0;
      foreach (key_cols[i]) key_cols[i] = 8'h00;
      sel_col    = 8'h00;
      last_level = 1'b0;
      last_or    = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_reads();
      test_column_loads();
      test_selection_reads();
      test_port_writes();
      test_line_changes();
      hold_until_drained();
      test_random_traffic(1300);

      req_ch.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("%0d requests and %0d responses checked under four idling phases;",
               requests_taken, responses_seen);
      $display("%0d IRQ asserts, %0d NMI pulses and %0d sound writes predicted, %0d mismatches.",
               irq_asserts, nmi_pulses, sound_writes, error_count);
      if (error_count == 0 && pending_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
